/* rtl/gbl_pkg.sv */
// Shared constants, types and helpers of the 7x7 Gaussian blur.
package gbl_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int Radius    = 3;
  localparam int Taps      = 2 * Radius + 1;
  localparam int HistDepth = 2 * Radius * MaxWidth + 2 * Radius + 1;
  localparam int AddrW     = $clog2(HistDepth);
  localparam int CntW      = 21;
  localparam int DimW      = 11;
  localparam int WtW       = 16;
  localparam int AccW      = 46;
  localparam int QuotW     = 11;

  // register byte addresses
  localparam logic [4:0] REG_IMAGE_WIDTH  = 5'd0;
  localparam logic [4:0] REG_IMAGE_HEIGHT = 5'd4;
  localparam logic [4:0] REG_TAP_CENTER   = 5'd8;
  localparam logic [4:0] REG_TAP_ONE      = 5'd12;
  localparam logic [4:0] REG_TAP_TWO      = 5'd16;
  localparam logic [4:0] REG_TAP_THREE    = 5'd20;

  typedef struct packed {
    logic [DimW-1:0] image_width;
    logic [DimW-1:0] image_height;
    logic [WtW-1:0]  tap_weight_center;
    logic [WtW-1:0]  tap_weight_one;
    logic [WtW-1:0]  tap_weight_two;
    logic [WtW-1:0]  tap_weight_three;
  } gbl_cfg_t;

  typedef struct packed {
    logic take;
    logic step;
    logic div_run;
    logic tap_run;
    logic finish;
  } gbl_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_last;
    logic tap_last;
    logic pipe_busy;
    logic out_free;
  } gbl_status_t;

  function automatic logic [7:0] sat8(input logic [AccW-1:0] acc);
    logic [AccW-33:0] v;
    v = acc[AccW-1:32];
    sat8 = (v > (AccW-32)'(255)) ? 8'hff : v[7:0];
  endfunction

endpackage

/* rtl/gbl_regs.sv */
// APB register file: geometry and 1D tap weights.
module gbl_regs
  import gbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output gbl_cfg_t    cfg
);

  logic wr;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width       <= DimW'(MaxWidth);
      cfg.image_height      <= DimW'(MaxHeight);
      cfg.tap_weight_center <= 16'hffff;
      cfg.tap_weight_one    <= '0;
      cfg.tap_weight_two    <= '0;
      cfg.tap_weight_three  <= '0;
    end else if (wr) begin
      case (paddr)
        REG_IMAGE_WIDTH:  cfg.image_width       <= pwdata[DimW-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height      <= pwdata[DimW-1:0];
        REG_TAP_CENTER:   cfg.tap_weight_center <= pwdata[WtW-1:0];
        REG_TAP_ONE:      cfg.tap_weight_one    <= pwdata[WtW-1:0];
        REG_TAP_TWO:      cfg.tap_weight_two    <= pwdata[WtW-1:0];
        REG_TAP_THREE:    cfg.tap_weight_three  <= pwdata[WtW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_IMAGE_WIDTH:  prdata = 32'(cfg.image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(cfg.image_height);
      REG_TAP_CENTER:   prdata = 32'(cfg.tap_weight_center);
      REG_TAP_ONE:      prdata = 32'(cfg.tap_weight_one);
      REG_TAP_TWO:      prdata = 32'(cfg.tap_weight_two);
      REG_TAP_THREE:    prdata = 32'(cfg.tap_weight_three);
      default:          prdata = '0;
    endcase
  end

endmodule

/* rtl/gbl_ctrl.sv */
// Sequencer: item intake, position divide, tap sweep, result hand-off.
module gbl_ctrl
  import gbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  gbl_status_t status,
  output gbl_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_STEP  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_TAPS  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        cmd.take = s_tvalid;
        if (s_tvalid) state_next = ST_STEP;
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        state_next = status.emit ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd.div_run = 1'b1;
        if (status.div_last) state_next = ST_TAPS;
      end
      ST_TAPS: begin
        cmd.tap_run = 1'b1;
        if (status.tap_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = status.out_free;
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/gbl_dp.sv */
// Datapath: pixel history, counters, divider, tap MAC pipeline, output word.
module gbl_dp
  import gbl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  gbl_cfg_t     cfg,
  input  gbl_cmd_t     cmd,
  output gbl_status_t  status,
  input  logic         in_flush,
  input  logic [23:0]  in_pix,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [23:0]  out_pix,
  output logic         out_last
);

  localparam logic [AddrW-1:0] DepthA = AddrW'(HistDepth);

  // geometry
  logic [DimW-1:0] eff_w, eff_h;
  logic [CntW-1:0] frame;
  logic [12:0]     lag;

  always_comb begin
    eff_w = cfg.image_width;
    if (eff_w == '0) eff_w = DimW'(1);
    else if (eff_w > DimW'(MaxWidth)) eff_w = DimW'(MaxWidth);
    eff_h = cfg.image_height;
    if (eff_h == '0) eff_h = DimW'(1);
    else if (eff_h > DimW'(MaxHeight)) eff_h = DimW'(MaxHeight);
  end

  assign frame = CntW'(eff_w) * CntW'(eff_h);
  assign lag   = 13'(eff_w) * 13'(Radius) + 13'(Radius);

  // latched item
  logic        item_flush;
  logic [23:0] item_pix;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_flush <= in_flush;
      item_pix   <= in_pix;
    end
  end

  // counters and history pointers
  logic [CntW-1:0]  ic, oc, ic0, oc0, ic1;
  logic [AddrW-1:0] wp, rp, wp0, rp0, wp_inc, rp_inc;
  logic             clr, take_pix, emit;

  always_comb begin
    clr      = (oc >= frame);
    ic0      = clr ? '0 : ic;
    oc0      = clr ? '0 : oc;
    wp0      = clr ? '0 : wp;
    rp0      = clr ? '0 : rp;
    ic1      = ic0 + CntW'(1);
    wp_inc   = (wp0 == DepthA - AddrW'(1)) ? '0 : wp0 + AddrW'(1);
    take_pix = !item_flush && (ic0 < frame);
    if (item_flush)
      emit = (ic0 >= frame) && (oc0 < frame);
    else
      emit = take_pix && ({1'b0, ic1} > ({1'b0, oc0} + (CntW+1)'(lag)));
  end

  logic             last_now;
  logic [CntW-1:0]  oc_inc;
  assign oc_inc   = oc + CntW'(1);
  assign last_now = (oc_inc >= frame);
  assign rp_inc   = (rp == DepthA - AddrW'(1)) ? '0 : rp + AddrW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ic <= '0;
      oc <= '0;
      wp <= '0;
      rp <= '0;
    end else if (cmd.step) begin
      ic <= take_pix ? ic1 : ic0;
      oc <= oc0;
      wp <= take_pix ? wp_inc : wp0;
      rp <= rp0;
    end else if (cmd.finish) begin
      if (last_now) begin
        ic <= '0;
        oc <= '0;
        wp <= '0;
        rp <= '0;
      end else begin
        oc <= oc_inc;
        rp <= rp_inc;
      end
    end
  end

  // pixel history
  logic [23:0]      store [HistDepth];
  logic [23:0]      rd_data;
  logic [AddrW-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (cmd.step && take_pix) store[wp0] <= item_pix;
  end

  always_ff @(posedge clk) begin
    if (cmd.tap_run) rd_data <= store[rd_addr];
  end

  // restoring divide of the output index by the width: row and column
  logic [CntW-1:0]  rem;
  logic [QuotW-1:0] quot;
  logic [3:0]       dcnt;
  logic [CntW:0]    den;
  logic             fits;
  logic             start;

  assign start = cmd.step && emit;
  assign den   = (CntW+1)'(eff_w) << dcnt;
  assign fits  = ({1'b0, rem} >= den);

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= oc0;
      quot <= '0;
      dcnt <= 4'(QuotW - 1);
    end else if (cmd.div_run) begin
      if (fits) rem <= CntW'({1'b0, rem} - den);
      quot <= {quot[QuotW-2:0], fits};
      dcnt <= dcnt - 4'd1;
    end
  end

  logic [DimW-1:0] kx, ky;
  assign kx = rem[DimW-1:0];
  assign ky = quot;

  // tap sweep
  logic [2:0] ty, tx;

  always_ff @(posedge clk) begin
    if (start) begin
      ty <= '0;
      tx <= '0;
    end else if (cmd.tap_run) begin
      if (tx == 3'(Taps - 1)) begin
        tx <= '0;
        ty <= ty + 3'd1;
      end else begin
        tx <= tx + 3'd1;
      end
    end
  end

  logic [DimW:0]  sx, sy;
  logic           inb;
  logic signed [15:0] tpos, tfix;

  always_comb begin
    sx   = {1'b0, kx} + (DimW+1)'(tx);
    sy   = {1'b0, ky} + (DimW+1)'(ty);
    inb  = (sx >= (DimW+1)'(Radius)) && (sx < {1'b0, eff_w} + (DimW+1)'(Radius)) &&
           (sy >= (DimW+1)'(Radius)) && (sy < {1'b0, eff_h} + (DimW+1)'(Radius));
    tpos = signed'(16'(rp)) + signed'(16'(14'(ty) * 14'(eff_w))) +
           signed'(16'(tx)) - signed'(16'(lag));
    if (tpos < 16'sd0)
      tfix = tpos + signed'(16'(HistDepth));
    else if (tpos >= signed'(16'(HistDepth)))
      tfix = tpos - signed'(16'(HistDepth));
    else
      tfix = tpos;
    rd_addr = inb ? tfix[AddrW-1:0] : rp;
  end

  function automatic logic [WtW-1:0] pick(input gbl_cfg_t c, input logic [2:0] t);
    logic [WtW-1:0] r;
    case (t)
      3'd3:        r = c.tap_weight_center;
      3'd2, 3'd4:  r = c.tap_weight_one;
      3'd1, 3'd5:  r = c.tap_weight_two;
      default:     r = c.tap_weight_three;
    endcase
    return r;
  endfunction

  logic [WtW-1:0] wa, wb;
  assign wa = pick(cfg, ty);
  assign wb = pick(cfg, tx);

  // MAC pipeline: read + weight, products, accumulate
  logic [31:0]     wt1;
  logic [39:0]     pr, pg, pb;
  logic [AccW-1:0] acc_r, acc_g, acc_b;
  logic            v1, v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.tap_run;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tap_run) wt1 <= wa * wb;
    if (v1) begin
      pr <= 40'(rd_data[7:0])   * 40'(wt1);
      pg <= 40'(rd_data[15:8])  * 40'(wt1);
      pb <= 40'(rd_data[23:16]) * 40'(wt1);
    end
    if (start) begin
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
    end else if (v2) begin
      acc_r <= acc_r + AccW'(pr);
      acc_g <= acc_g + AccW'(pg);
      acc_b <= acc_b + AccW'(pb);
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_pix  <= {sat8(acc_b), sat8(acc_g), sat8(acc_r)};
      out_last <= last_now;
    end
  end

  assign status.emit      = emit;
  assign status.div_last  = (dcnt == 4'd0);
  assign status.tap_last  = (ty == 3'(Taps - 1)) && (tx == 3'(Taps - 1));
  assign status.pipe_busy = v1 | v2;
  assign status.out_free  = !out_valid || out_ready;

endmodule

/* rtl/gaussian_blur_7x7.sv */
// A pixel or flush word that yields a result passes through the update, divide,
// tap sweep, pipeline drain and output load steps in that order after acceptance.
// Taps go through the single history read port and MAC set at one tap per cycle;
// the next word is taken only after the last one is done and its result loaded.
// Reset clears counters, output valid and config registers to their defaults;
// the pixel history is not cleared.
module gaussian_blur_7x7
  import gbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
  input  logic        s_tuser,   // flush
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red_out, green_out, blue_out
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gbl_cfg_t    cfg;
  gbl_cmd_t    cmd;
  gbl_status_t status;

  assign pready = 1'b1;

  gbl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  gbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gbl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .in_flush  (s_tuser),
    .in_pix    (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pix   (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

/* rtl/gbl_checker.sv */
// Port-level checks of the blur block and their binding.
module gbl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast,
  input logic        pready
);

  // a held output word keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // one word at a time: intake closes after each accepted word
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while busy");

  // no output word right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a result never shows up in the cycle right after an accept
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result too early");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind gaussian_blur_7x7 gbl_checker u_gbl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .pready   (pready)
);
